### src/opcode_framed_reply_parser_macros.svh
// assertion macros for the reply parser checker
// expects clk and arst_n in the scope of use
`ifndef OPCODE_FRAMED_REPLY_PARSER_MACROS_SVH
`define OPCODE_FRAMED_REPLY_PARSER_MACROS_SVH

// property checked at every rising clock edge outside reset
`define OFRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form
`define OFRP_ASSERT_IMPL(lbl, ante, cons, msg) \
	`OFRP_ASSERT(lbl, (ante) |-> (cons), msg)

// implication whose consequent is checked in the cycle after the antecedent
`define OFRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	`OFRP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### src/ofrp_pkg.sv
// opcodes, frame lengths, kind codes and decode functions of the reply parser
// no dependencies
package ofrp_pkg;

	localparam logic [7:0] OP_GAIN_RPT = 8'h18;
	localparam logic [7:0] OP_GAIN_ACK = 8'h28;
	localparam logic [7:0] OP_TEMP_RPT = 8'h38;
	localparam logic [7:0] OP_TEMP_ACK = 8'h48;
	localparam logic [7:0] OP_L1       = 8'h50;
	localparam logic [7:0] OP_T1       = 8'h58;
	localparam logic [7:0] OP_L2       = 8'h60;
	localparam logic [7:0] OP_L3       = 8'h68;
	localparam logic [7:0] OP_TC_ON    = 8'h70;
	localparam logic [7:0] OP_TC_OFF   = 8'h78;
	localparam logic [7:0] OP_SYS_ON   = 8'h80;
	localparam logic [7:0] OP_SYS_OFF  = 8'h84;
	localparam logic [7:0] OP_CLOSED   = 8'h88;
	localparam logic [7:0] OP_SKIP     = 8'h98;
	localparam logic [7:0] OP_SAMPLE   = 8'hc0;

	// payload bytes after the opcode
	localparam logic [2:0] LEN_GAIN  = 3'd6;
	localparam logic [2:0] LEN_SHORT = 3'd2;
	localparam logic [2:0] LEN_SKIP  = 3'd1;
	localparam logic [2:0] LEN_NONE  = 3'd0;

	localparam int unsigned STORE_DEPTH = 6;

	typedef enum logic [3:0] {
		KIND_GAIN_RPT = 4'd0,
		KIND_GAIN_ACK = 4'd1,
		KIND_TEMP_RPT = 4'd2,
		KIND_TEMP_ACK = 4'd3,
		KIND_L1       = 4'd4,
		KIND_T1       = 4'd5,
		KIND_L2       = 4'd6,
		KIND_L3       = 4'd7,
		KIND_TC_ON    = 4'd8,
		KIND_TC_OFF   = 4'd9,
		KIND_SYS_ON   = 4'd10,
		KIND_SYS_OFF  = 4'd11,
		KIND_CLOSED   = 4'd12,
		KIND_SAMPLE   = 4'd13,
		KIND_ERROR    = 4'd14
	} kind_t;

	function automatic logic op_known(logic [7:0] op);
		case (op) inside
			OP_GAIN_RPT, OP_GAIN_ACK, OP_TEMP_RPT, OP_TEMP_ACK, OP_L1, OP_T1,
			OP_L2, OP_L3, OP_TC_ON, OP_TC_OFF, OP_SYS_ON, OP_SYS_OFF,
			OP_CLOSED, OP_SKIP, OP_SAMPLE: op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
	endfunction

	function automatic logic [2:0] op_len(logic [7:0] op);
		case (op) inside
			OP_GAIN_RPT, OP_GAIN_ACK: op_len = LEN_GAIN;
			OP_TEMP_RPT, OP_TEMP_ACK, OP_L1, OP_T1, OP_L2, OP_L3,
			OP_SAMPLE: op_len = LEN_SHORT;
			OP_SKIP: op_len = LEN_SKIP;
			default: op_len = LEN_NONE;
		endcase
	endfunction

	function automatic kind_t op_kind(logic [7:0] op);
		case (op)
			OP_GAIN_RPT: op_kind = KIND_GAIN_RPT;
			OP_GAIN_ACK: op_kind = KIND_GAIN_ACK;
			OP_TEMP_RPT: op_kind = KIND_TEMP_RPT;
			OP_TEMP_ACK: op_kind = KIND_TEMP_ACK;
			OP_L1:       op_kind = KIND_L1;
			OP_T1:       op_kind = KIND_T1;
			OP_L2:       op_kind = KIND_L2;
			OP_L3:       op_kind = KIND_L3;
			OP_TC_ON:    op_kind = KIND_TC_ON;
			OP_TC_OFF:   op_kind = KIND_TC_OFF;
			OP_SYS_ON:   op_kind = KIND_SYS_ON;
			OP_SYS_OFF:  op_kind = KIND_SYS_OFF;
			OP_CLOSED:   op_kind = KIND_CLOSED;
			OP_SAMPLE:   op_kind = KIND_SAMPLE;
			default:     op_kind = KIND_ERROR;
		endcase
	endfunction

endpackage

### src/opcode_framed_reply_parser.sv
// Reply parser: takes one byte beat per cycle and gives one decoded message per
// complete frame but a skip frame, or an error message per unknown byte, in the
// cycle after its last byte. Parser state, payload bytes and output register
// are the only storage; input stalls only while a message waits unaccepted.
// depends on ofrp_pkg
module opcode_framed_reply_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ofrp_pkg::kind_t      kind,
	output logic [15:0]          value_a,
	output logic signed [15:0]   value_b,
	output logic [15:0]          value_c,
	output logic                 link_up
);
	import ofrp_pkg::*;

	logic [7:0] frame_op_q;
	logic [2:0] pending_q;
	logic [7:0] store_q [STORE_DEPTH];
	logic       board_up_q;

	logic               out_valid_q;
	kind_t              kind_q;
	logic [15:0]        value_a_q;
	logic signed [15:0] value_b_q;
	logic [15:0]        value_c_q;
	logic               link_up_q;

	logic               fire;
	logic               in_frame;
	logic [7:0]         op;
	logic [2:0]         len;
	logic [2:0]         idx;
	logic               known;
	logic               produce;
	logic [2:0]         pending_n;
	logic [7:0]         frame_op_n;
	logic               board_up_n;
	kind_t              kind_n;
	logic [15:0]        value_a_n;
	logic signed [15:0] value_b_n;
	logic [15:0]        value_c_n;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign in_frame = pending_q != 3'd0;
	assign op       = in_frame ? frame_op_q : rx_byte;
	assign len      = op_len(op);
	assign known    = op_known(op);
	assign idx      = len - pending_q;

	always_comb begin
		produce    = 1'b0;
		pending_n  = pending_q;
		frame_op_n = frame_op_q;
		board_up_n = board_up_q;
		if (in_frame) begin
			pending_n = pending_q - 3'd1;
			if (pending_q == 3'd1 && frame_op_q != OP_SKIP) begin
				produce = 1'b1;
			end
		end else if (!known) begin
			produce = 1'b1;
		end else begin
			frame_op_n = rx_byte;
			pending_n  = len;
			if (len == LEN_NONE) begin
				produce = 1'b1;
				if (rx_byte == OP_SYS_ON) begin
					board_up_n = 1'b1;
				end else if (rx_byte == OP_SYS_OFF) begin
					board_up_n = 1'b0;
				end
			end
		end
	end

	always_comb begin
		kind_n    = known ? op_kind(op) : KIND_ERROR;
		value_a_n = 16'd0;
		value_b_n = 16'sd0;
		value_c_n = 16'd0;
		if (!known) begin
			value_a_n = {8'h00, rx_byte};
		end else if (len == LEN_GAIN) begin
			value_a_n = {store_q[0], store_q[1]};
			value_b_n = signed'({store_q[2], store_q[3]});
			value_c_n = {store_q[4], rx_byte};
		end else if (len == LEN_SHORT) begin
			value_a_n = {store_q[0], rx_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_op_q <= 8'h00;
			pending_q  <= 3'd0;
			board_up_q <= 1'b0;
		end else if (fire) begin
			frame_op_q <= frame_op_n;
			pending_q  <= pending_n;
			board_up_q <= board_up_n;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (fire && in_frame) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				if (idx == 3'(i)) begin
					store_q[i] <= rx_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= produce;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			kind_q    <= kind_n;
			value_a_q <= value_a_n;
			value_b_q <= value_b_n;
			value_c_q <= value_c_n;
			link_up_q <= board_up_n;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value_a   = value_a_q;
	assign value_b   = value_b_q;
	assign value_c   = value_c_q;
	assign link_up   = link_up_q;

endmodule

### src/ofrp_checker.sv
// port-level checks of the reply parser, bound to the parser module
// depends on ofrp_pkg and opcode_framed_reply_parser_macros.svh
`include "opcode_framed_reply_parser_macros.svh"

module ofrp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input ofrp_pkg::kind_t      kind,
	input logic [15:0]          value_a,
	input logic signed [15:0]   value_b,
	input logic [15:0]          value_c,
	input logic                 link_up
);
	import ofrp_pkg::*;

	// stalled beat holds
	`OFRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(value_a) && $stable(value_b) && $stable(value_c) && $stable(link_up), "output beat changed while stalled")
	// a message only follows an accepted byte
	`OFRP_ASSERT_IMPL(a_out_cause, $rose(out_valid), $past(in_valid && in_ready), "message without input beat")
	// only gain messages carry second and third values
	`OFRP_ASSERT_IMPL(a_gain_only, out_valid && kind != KIND_GAIN_RPT && kind != KIND_GAIN_ACK, value_b == 16'sd0 && value_c == 16'd0, "nonzero value outside gain message")
	// link flag follows enable and disable replies
	`OFRP_ASSERT_IMPL(a_link_flag, out_valid && (kind == KIND_SYS_ON || kind == KIND_SYS_OFF), link_up == (kind == KIND_SYS_ON), "link flag does not match reply")
	// errors carry only the offending byte
	`OFRP_ASSERT_IMPL(a_err_byte, out_valid && kind == KIND_ERROR, value_a[15:8] == 8'h00, "error value wider than a byte")

endmodule

bind opcode_framed_reply_parser ofrp_checker u_ofrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.value_a   (value_a),
	.value_b   (value_b),
	.value_c   (value_c),
	.link_up   (link_up)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// testbench for opcode_framed_reply_parser: directed and random reply frames,
// random idling on both sides, results checked against an in-bench decoder
// depends on ofrp_pkg and the parser rtl
module tb_top;
	import ofrp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_BYTES = 500;
	localparam int IDLE_PCT = 37;

	typedef struct packed {
		kind_t              kind;
		logic [15:0]        value_a;
		logic signed [15:0] value_b;
		logic [15:0]        value_c;
		logic               link_up;
	} reply_msg_t;

	class reply_msg_tracker;
		reply_msg_t msgs_due[$];
		logic [7:0] open_op;
		int         bytes_left;
		logic [7:0] payload[6];
		logic       board_up;
		int         errors;

		function new();
			open_op = '0;
			bytes_left = 0;
			board_up = 1'b0;
			errors = 0;
			foreach (payload[i])
				payload[i] = '0;
		endfunction

		// payload bytes after an opcode, -1 for a byte that is no opcode
		function int frame_len(logic [7:0] op);
			case (op)
				OP_GAIN_RPT, OP_GAIN_ACK: return 6;
				OP_TEMP_RPT, OP_TEMP_ACK, OP_L1, OP_T1, OP_L2, OP_L3, OP_SAMPLE: return 2;
				OP_SKIP: return 1;
				OP_TC_ON, OP_TC_OFF, OP_SYS_ON, OP_SYS_OFF, OP_CLOSED: return 0;
				default: return -1;
			endcase
		endfunction

		function kind_t kind_for(logic [7:0] op);
			case (op)
				OP_GAIN_RPT: return KIND_GAIN_RPT;
				OP_GAIN_ACK: return KIND_GAIN_ACK;
				OP_TEMP_RPT: return KIND_TEMP_RPT;
				OP_TEMP_ACK: return KIND_TEMP_ACK;
				OP_L1:       return KIND_L1;
				OP_T1:       return KIND_T1;
				OP_L2:       return KIND_L2;
				OP_L3:       return KIND_L3;
				OP_TC_ON:    return KIND_TC_ON;
				OP_TC_OFF:   return KIND_TC_OFF;
				OP_SYS_ON:   return KIND_SYS_ON;
				OP_SYS_OFF:  return KIND_SYS_OFF;
				OP_CLOSED:   return KIND_CLOSED;
				OP_SAMPLE:   return KIND_SAMPLE;
				default:     return KIND_ERROR;
			endcase
		endfunction

		function void decode_frame(logic [7:0] op);
			reply_msg_t m;
			int len;
			len = frame_len(op);
			if (op == OP_SYS_ON)
				board_up = 1'b1;
			else if (op == OP_SYS_OFF)
				board_up = 1'b0;
			m.kind = kind_for(op);
			m.value_a = (len >= 2) ? {payload[0], payload[1]} : 16'h0;
			m.value_b = (len == 6) ? {payload[2], payload[3]} : 16'h0;
			m.value_c = (len == 6) ? {payload[4], payload[5]} : 16'h0;
			m.link_up = board_up;
			msgs_due.push_back(m);
		endfunction

		function void take_byte(logic [7:0] b);
			reply_msg_t m;
			int len;
			if (bytes_left != 0) begin
				len = frame_len(open_op);
				payload[len - bytes_left] = b;
				bytes_left--;
				if (bytes_left == 0 && open_op != OP_SKIP)
					decode_frame(open_op);
				return;
			end
			len = frame_len(b);
			if (len < 0) begin
				m.kind = KIND_ERROR;
				m.value_a = {8'h00, b};
				m.value_b = 16'h0;
				m.value_c = 16'h0;
				m.link_up = board_up;
				msgs_due.push_back(m);
			end else begin
				open_op = b;
				if (len == 0)
					decode_frame(b);
				else
					bytes_left = len;
			end
		endfunction

		function void match_msg(reply_msg_t got);
			reply_msg_t want;
			if (msgs_due.size() == 0) begin
				$display("%0t unexpected message: kind %0d a %h b %h c %h link %b", $time,
					got.kind, got.value_a, got.value_b, got.value_c, got.link_up);
				errors++;
				return;
			end
			want = msgs_due.pop_front();
			if (got !== want) begin
				$display("%0t mismatch: expected kind %0d a %h b %h c %h link %b", $time,
					want.kind, want.value_a, want.value_b, want.value_c, want.link_up);
				$display("%0t            actual kind %0d a %h b %h c %h link %b", $time,
					got.kind, got.value_a, got.value_b, got.value_c, got.link_up);
				errors++;
			end
		endfunction

		function int waiting();
			return msgs_due.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	kind_t              kind;
	logic [15:0]        value_a;
	logic signed [15:0] value_b;
	logic [15:0]        value_c;
	logic               link_up;

	reply_msg_tracker trk = new();
	int  cycles = 0;
	int  nsent = 0;
	bit  steady = 1'b0;
	bit  hold_req = 1'b0;

	localparam logic [7:0] VALID_OPS [15] = '{
		OP_GAIN_RPT, OP_GAIN_ACK, OP_TEMP_RPT, OP_TEMP_ACK, OP_L1, OP_T1, OP_L2,
		OP_L3, OP_TC_ON, OP_TC_OFF, OP_SYS_ON, OP_SYS_OFF, OP_CLOSED, OP_SKIP,
		OP_SAMPLE
	};

	// errors at both ends, link up, gain extremes, skip of an opcode-like byte
	localparam logic [7:0] DIRECTED [26] = '{
		8'h00, 8'hff, OP_SYS_ON,
		OP_GAIN_RPT, 8'hff, 8'hff, 8'h80, 8'h00, 8'h00, 8'h01,
		OP_SKIP, OP_GAIN_RPT,
		OP_SAMPLE, 8'h00, 8'hff,
		OP_SYS_OFF, OP_TC_ON, OP_TC_OFF, OP_CLOSED,
		OP_GAIN_ACK, 8'h00, 8'h00, 8'h7f, 8'hff, 8'hff, 8'hff
	};

	opcode_framed_reply_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value_a   (value_a),
		.value_b   (value_b),
		.value_c   (value_c),
		.link_up   (link_up)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			trk.take_byte(rx_byte);
		if (arst_n && out_valid && out_ready)
			trk.match_msg('{kind, value_a, value_b, value_c, link_up});
	end

	// receiver side
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		if (!steady)
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		nsent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] payload_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'h7f;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_frame();
		logic [7:0] op;
		int len;
		op = VALID_OPS[$urandom_range(14)];
		len = trk.frame_len(op);
		send_byte(op);
		repeat (len) send_byte(payload_byte());
	endtask

	task automatic drain();
		while (trk.waiting() != 0)
			@(negedge clk);
	endtask

	initial begin
		bit held;
		held = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);
		in_valid <= 1'b0;
		@(negedge clk);
		drain();

		nsent = 0;
		while (nsent < RANDOM_BYTES) begin
			if (!held && nsent >= 120) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			steady = (nsent >= 250 && nsent < 350);
			if (nsent >= 400 && nsent < 410) begin
				in_valid <= 1'b0;
				@(negedge clk);
				drain();
			end
			if ($urandom_range(99) < 85)
				send_frame();
			else
				send_byte(8'($urandom_range(255)));
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		drain();
		repeat (8) @(negedge clk);
		if (trk.errors == 0 && trk.waiting() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
